FILE: rtl/core/ppm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

    localparam int DIM_BITS_DEF = 16;
    localparam int OUT_DIM_W    = 16;

    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_SIX     = 8'h36;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [1:0] ST_HEADER = 2'd0;
    localparam logic [1:0] ST_PIXEL  = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    typedef struct packed {
        logic [1:0]           status;
        logic [7:0]           pixel_byte;
        logic [OUT_DIM_W-1:0] image_width;
        logic [OUT_DIM_W-1:0] image_height;
        logic                 image_done;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/ppm_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface ppm_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [7:0]                     pixel_byte;
    logic [ppm_pkg::OUT_DIM_W-1:0]  image_width;
    logic [ppm_pkg::OUT_DIM_W-1:0]  image_height;
    logic                           image_done;

    modport source (
        output valid, output status, output pixel_byte, output image_width,
        output image_height, output image_done, input ready
    );
    modport sink (
        input valid, input status, input pixel_byte, input image_width,
        input image_height, input image_done, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/ppm_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ppm_parse_core #(
    parameter int DIM_BITS = ppm_pkg::DIM_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    output ppm_pkg::t_result       o_result
);

    localparam logic [3:0] PH_MAGIC0  = 4'd0;
    localparam logic [3:0] PH_MAGIC1  = 4'd1;
    localparam logic [3:0] PH_SKIPMAG = 4'd2;
    localparam logic [3:0] PH_CMTCHK  = 4'd3;
    localparam logic [3:0] PH_CMTSKIP = 4'd4;
    localparam logic [3:0] PH_WIDTH   = 4'd5;
    localparam logic [3:0] PH_HEIGHT  = 4'd6;
    localparam logic [3:0] PH_MAXVAL  = 4'd7;
    localparam logic [3:0] PH_PIXELS  = 4'd8;
    localparam logic [3:0] PH_ERROR   = 4'd9;

    localparam int OW = ppm_pkg::OUT_DIM_W;

    logic [3:0]          r_phase, n_phase;
    logic [DIM_BITS-1:0] r_width, n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic                r_frozen, n_frozen;
    logic [1:0]          r_comp, n_comp;
    logic [DIM_BITS-1:0] r_col, n_col;
    logic [DIM_BITS-1:0] r_row, n_row;

    logic                is_digit;
    logic [DIM_BITS-1:0] digit_val;
    logic [DIM_BITS-1:0] width_x10;
    logic [DIM_BITS-1:0] height_x10;
    logic [DIM_BITS:0]   col_inc;
    logic [DIM_BITS:0]   row_inc;

    assign is_digit   = (i_byte >= ppm_pkg::CH_ZERO) && (i_byte <= ppm_pkg::CH_NINE);
    assign digit_val  = DIM_BITS'(i_byte - ppm_pkg::CH_ZERO);
    assign width_x10  = (r_width << 3) + (r_width << 1) + digit_val;
    assign height_x10 = (r_height << 3) + (r_height << 1) + digit_val;
    assign col_inc    = {1'b0, r_col} + {{DIM_BITS{1'b0}}, 1'b1};
    assign row_inc    = {1'b0, r_row} + {{DIM_BITS{1'b0}}, 1'b1};

    always_comb begin
        n_phase  = r_phase;
        n_width  = r_width;
        n_height = r_height;
        n_frozen = r_frozen;
        n_comp   = r_comp;
        n_col    = r_col;
        n_row    = r_row;
        o_result.status     = ppm_pkg::ST_HEADER;
        o_result.pixel_byte = 8'd0;
        o_result.image_done = 1'b0;

        case (r_phase)
            PH_MAGIC0: begin
                if (i_byte == ppm_pkg::CH_P) begin
                    n_phase = PH_MAGIC1;
                end else begin
                    n_phase = PH_ERROR;
                    o_result.status = ppm_pkg::ST_ERROR;
                end
            end
            PH_MAGIC1: begin
                if (i_byte == ppm_pkg::CH_SIX) begin
                    n_phase  = PH_SKIPMAG;
                    n_width  = '0;
                    n_height = '0;
                    n_frozen = 1'b0;
                    n_comp   = 2'd0;
                    n_col    = '0;
                    n_row    = '0;
                end else begin
                    n_phase = PH_ERROR;
                    o_result.status = ppm_pkg::ST_ERROR;
                end
            end
            PH_SKIPMAG, PH_CMTSKIP: begin
                if (i_byte == ppm_pkg::CH_NEWLINE) begin
                    n_phase = PH_CMTCHK;
                end
            end
            PH_CMTCHK, PH_WIDTH: begin
                if ((r_phase == PH_CMTCHK) && (i_byte == ppm_pkg::CH_HASH)) begin
                    n_phase = PH_CMTSKIP;
                end else if (i_byte == ppm_pkg::CH_SPACE) begin
                    n_frozen = 1'b0;
                    n_phase  = PH_HEIGHT;
                end else begin
                    n_phase = PH_WIDTH;
                    if (!r_frozen) begin
                        if (is_digit) begin
                            n_width = width_x10;
                        end else begin
                            n_frozen = 1'b1;
                        end
                    end
                end
            end
            PH_HEIGHT: begin
                if (i_byte == ppm_pkg::CH_NEWLINE) begin
                    n_frozen = 1'b0;
                    n_phase  = PH_MAXVAL;
                end else if (!r_frozen) begin
                    if (is_digit) begin
                        n_height = height_x10;
                    end else begin
                        n_frozen = 1'b1;
                    end
                end
            end
            PH_MAXVAL: begin
                if (i_byte == ppm_pkg::CH_NEWLINE) begin
                    if ((r_width == '0) || (r_height == '0)) begin
                        o_result.image_done = 1'b1;
                        n_phase = PH_MAGIC0;
                    end else begin
                        n_comp  = 2'd0;
                        n_col   = '0;
                        n_row   = '0;
                        n_phase = PH_PIXELS;
                    end
                end
            end
            PH_PIXELS: begin
                o_result.status     = ppm_pkg::ST_PIXEL;
                o_result.pixel_byte = i_byte;
                if (r_comp < 2'd2) begin
                    n_comp = r_comp + 2'd1;
                end else begin
                    n_comp = 2'd0;
                    if (col_inc < {1'b0, r_width}) begin
                        n_col = col_inc[DIM_BITS-1:0];
                    end else begin
                        n_col = '0;
                        if (row_inc < {1'b0, r_height}) begin
                            n_row = row_inc[DIM_BITS-1:0];
                        end else begin
                            n_row = '0;
                            o_result.image_done = 1'b1;
                            n_phase = PH_MAGIC0;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_ERROR;
                o_result.status = ppm_pkg::ST_ERROR;
            end
        endcase

        o_result.image_width  = OW'(n_width);
        o_result.image_height = OW'(n_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC0;
            r_width  <= '0;
            r_height <= '0;
            r_frozen <= 1'b0;
            r_comp   <= 2'd0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_width  <= n_width;
            r_height <= n_height;
            r_frozen <= n_frozen;
            r_comp   <= n_comp;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ppm_p6_stream_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Carries
// i_in    | in        | in_byte, one byte of the PPM file per transaction
// o_out   | out       | status, pixel_byte, image_width, image_height, image_done
//
// Every input byte gives exactly one output transaction, through the input register
// and then the output register. One byte per cycle is sustained while o_out is not
// stalled; parser state updates as a byte moves from input to output register.
// Reset is synchronous and active low; it empties both registers and returns the
// parser to waiting for the first magic byte. A stall on o_out holds the output
// register and, once the input register is also full, deasserts i_in.ready.

module ppm_p6_stream_parser #(
    parameter int DIM_BITS = ppm_pkg::DIM_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ppm_in_if.sink     i_in,
    ppm_out_if.source  o_out
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    ppm_pkg::t_result r_out;
    ppm_pkg::t_result core_result;
    logic             advance;
    logic             step;

    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    ppm_parse_core #(
        .DIM_BITS (DIM_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.pixel_byte   = r_out.pixel_byte;
    assign o_out.image_width  = r_out.image_width;
    assign o_out.image_height = r_out.image_height;
    assign o_out.image_done   = r_out.image_done;

endmodule

`default_nettype wire

FILE: rtl/core/ppm_parse_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module ppm_parse_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [1:0]                    i_status,
    input wire logic [7:0]                    i_pixel_byte,
    input wire logic [ppm_pkg::OUT_DIM_W-1:0] i_image_width,
    input wire logic [ppm_pkg::OUT_DIM_W-1:0] i_image_height,
    input wire logic                          i_image_done
);

    // A stalled transaction keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_pixel_byte) && $stable(i_image_width)
            && $stable(i_image_height) && $stable(i_image_done))
        else $error("output payload changed during a stall");

    // A format error stays until reset.
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ppm_pkg::ST_ERROR
            |=> !i_out_valid || i_status == ppm_pkg::ST_ERROR)
        else $error("format error was not sticky");

    // Image completion never comes with an error.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_image_done |-> i_status != ppm_pkg::ST_ERROR)
        else $error("image completed on an error transaction");

    // Pixel data is zero on anything but a pixel transaction.
    a_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ppm_pkg::ST_PIXEL |-> i_pixel_byte == 8'd0)
        else $error("pixel byte set on a header or error transaction");

endmodule

bind ppm_p6_stream_parser ppm_parse_chk u_ppm_parse_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_pixel_byte   (o_out.pixel_byte),
    .i_image_width  (o_out.image_width),
    .i_image_height (o_out.image_height),
    .i_image_done   (o_out.image_done)
);

`default_nettype wire
